### rtl/whu_pkg.sv
`default_nettype none

package whu_pkg;

    // Field widths.
    localparam int MULT_W    = 16;
    localparam int MOD_W     = 31;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_COMP  = 4;
    localparam int MAX_RUN   = 64;

    // Long division of (mult * comp) * 2^32 by the modulus, one bit a cycle.
    localparam int PROD_W    = MULT_W + MOD_W;
    localparam int DIV_W     = PROD_W + VAL_W;
    localparam int STEP_W    = $clog2(DIV_W);
    // Step after which the running remainder is the new component value.
    localparam int REM_STEP  = PROD_W - 1;

    // Commands.
    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_LOAD     = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MULT_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_Y  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_Z  = 3'd7;

    // Reset values, one per component (w, x, y, z).
    localparam logic [MULT_W-1:0] MULT_RESET [NUM_COMP] = '{
        16'd11600, 16'd47003, 16'd23000, 16'd33000
    };
    localparam logic [MOD_W-1:0] MOD_RESET [NUM_COMP] = '{
        31'd2147483579, 31'd2147483543, 31'd2147483423, 31'd2147483123
    };
    localparam logic [MOD_W-1:0] COMP_RESET [NUM_COMP] = '{
        31'd123456, 31'd102938, 31'd394875, 31'd765432
    };

    // Payload of one input transfer.
    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] count;
        logic [MOD_W-1:0] seed_w;
        logic [MOD_W-1:0] seed_x;
        logic [MOD_W-1:0] seed_y;
        logic [MOD_W-1:0] seed_z;
    } t_in_item;

    // Payload of one result transfer.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_out_item;

    // Payload of one configuration write.
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [MOD_W-1:0]     data;
    } t_cfg_item;

    // Control from the sequencer to each component lane.
    typedef struct packed {
        logic start;
        logic load;
    } t_lane_ctl;

endpackage

`default_nettype wire

### rtl/whu_if.sv
`default_nettype none

// Input item channel.
interface whu_in_if;
    logic              valid;
    logic              ready;
    whu_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Result channel.
interface whu_out_if;
    logic               valid;
    logic               ready;
    whu_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// Configuration write channel.
interface whu_cfg_if;
    logic               valid;
    logic               ready;
    whu_pkg::t_cfg_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

### rtl/whu_lane.sv
`default_nettype none

// One congruential component. On start the product mult * comp is formed
// and then divided by the modulus one bit a cycle, with 32 zero bits
// appended. After the product bits the remainder is the advanced component;
// the last 32 quotient bits are floor(comp * 2^32 / mod).
module whu_lane (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  whu_pkg::t_lane_ctl   i_ctl,
    input  wire  [whu_pkg::MOD_W-1:0]  i_seed,
    input  wire  [whu_pkg::MOD_W-1:0]  i_init,
    input  wire  [whu_pkg::MULT_W-1:0] i_mult,
    input  wire  [whu_pkg::MOD_W-1:0]  i_mod,
    output logic [whu_pkg::VAL_W-1:0]  o_frac,
    output logic                       o_busy
);
    import whu_pkg::*;

    logic [MOD_W-1:0]  r_comp;
    logic [DIV_W-1:0]  r_div;
    logic [MOD_W-1:0]  r_rem;
    logic [VAL_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;

    logic [PROD_W-1:0] prod;
    logic [MOD_W:0]    trial;
    logic [MOD_W-1:0]  diff;
    logic              ge;
    logic [MOD_W-1:0]  n_rem;
    logic              mod_small;

    // A modulus below two forces the component and its fraction to zero.
    assign mod_small = (i_mod[MOD_W-1:1] == '0);

    // Product of multiplier and current component.
    assign prod = i_mult * r_comp;

    // One restoring division step. The difference is only kept when it is
    // below the modulus, so its low bits are all that is needed.
    always_comb begin
        trial = {r_rem, r_div[DIV_W-1]};
        diff  = trial[MOD_W-1:0] - i_mod;
        ge    = (trial >= {1'b0, i_mod});
        n_rem = ge ? diff : trial[MOD_W-1:0];
    end

    // Component state and division shift registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp <= i_init;
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_ctl.load) begin
            r_comp <= i_seed;
        end else if (i_ctl.start) begin
            r_div  <= {prod, {VAL_W{1'b0}}};
            r_rem  <= '0;
            r_step <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_div  <= {r_div[DIV_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quo  <= {r_quo[VAL_W-2:0], ge};
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(REM_STEP)) begin
                r_comp <= mod_small ? '0 : n_rem;
            end
            if (r_step == STEP_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_frac = mod_small ? '0 : r_quo;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

### rtl/wichmann_hill_ii_uniform_generator_top.sv
`default_nettype none

// Channel   Direction  Payload                                   Transfer when
// i_in      in         cmd, count, seed_w, seed_x, seed_y, seed_z valid & ready
// o_out     out        value, last                               valid & ready
// i_cfg     in         index, data                               valid & ready
//
// A load command yields no values. Each value of a generate run is a start and
// then 79 single-bit steps of the four component dividers, which run side by side.
// Reset is synchronous; it restores the multipliers, moduli and seeds.
// A result waits in the output register while the next value is computed;
// the dividers then hold until that register is free. i_cfg is always ready.
module wichmann_hill_ii_uniform_generator_top (
    input  wire       i_clk,
    input  wire       i_rst_n,
    whu_in_if.sink    i_in,
    whu_out_if.source o_out,
    whu_cfg_if.sink   i_cfg
);
    import whu_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_remaining;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [MULT_W-1:0] r_mult [NUM_COMP];
    logic [MOD_W-1:0]  r_mod  [NUM_COMP];

    t_lane_ctl         lane_ctl;
    logic [VAL_W-1:0]  frac [NUM_COMP];
    logic [NUM_COMP-1:0] busy;
    logic [MOD_W-1:0]  seed [NUM_COMP];
    logic              accept;
    logic              gen_go;
    logic [CNT_W-1:0]  count_sat;
    logic              slot_free;
    logic              emit;
    logic [VAL_W-1:0]  sum;

    assign seed[0] = i_in.item.seed_w;
    assign seed[1] = i_in.item.seed_x;
    assign seed[2] = i_in.item.seed_y;
    assign seed[3] = i_in.item.seed_z;

    // Component lanes.
    for (genvar k = 0; k < NUM_COMP; k++) begin : g_lane
        whu_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_seed  (seed[k]),
            .i_init  (COMP_RESET[k]),
            .i_mult  (r_mult[k]),
            .i_mod   (r_mod[k]),
            .o_frac  (frac[k]),
            .o_busy  (busy[k])
        );
    end

    // Handshake and sequencing decisions.
    always_comb begin
        accept    = i_in.valid && (r_state == ST_IDLE);
        count_sat = (i_in.item.count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN)
                                                        : i_in.item.count;
        gen_go    = accept && (i_in.item.cmd == CMD_GENERATE) && (count_sat != '0);
        slot_free = !r_out_valid || o_out.ready;
        emit      = (r_state == ST_RUN) && (busy == '0) && slot_free;
        lane_ctl.load  = accept && (i_in.item.cmd == CMD_LOAD);
        lane_ctl.start = gen_go || (emit && (r_remaining != CNT_W'(1)));
        sum = frac[0] + frac[1] + frac[2] + frac[3];
    end

    // Sequencer state, output register and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_remaining <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_COMP; k++) begin
                r_mult[k] <= MULT_RESET[k];
                r_mod[k]  <= MOD_RESET[k];
            end
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (gen_go) begin
                        r_remaining <= count_sat;
                        r_state     <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (emit) begin
                        r_out_valid <= 1'b1;
                        r_out.value <= sum;
                        r_out.last  <= (r_remaining == CNT_W'(1));
                        r_remaining <= r_remaining - 1'b1;
                        if (r_remaining == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // Configuration writes.
            if (i_cfg.valid) begin
                case (i_cfg.item.index)
                    REG_MULT_W: r_mult[0] <= i_cfg.item.data[MULT_W-1:0];
                    REG_MULT_X: r_mult[1] <= i_cfg.item.data[MULT_W-1:0];
                    REG_MULT_Y: r_mult[2] <= i_cfg.item.data[MULT_W-1:0];
                    REG_MULT_Z: r_mult[3] <= i_cfg.item.data[MULT_W-1:0];
                    REG_MOD_W:  r_mod[0]  <= i_cfg.item.data;
                    REG_MOD_X:  r_mod[1]  <= i_cfg.item.data;
                    REG_MOD_Y:  r_mod[2]  <= i_cfg.item.data;
                    REG_MOD_Z:  r_mod[3]  <= i_cfg.item.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;
    assign i_cfg.ready = 1'b1;

    // The four lanes always start and finish together.
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy == '0) || (busy == '1))
        else $error("component lanes out of step");

    // No values are owed while idle, and some are owed while running.
    a_idle_owes_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_remaining == '0))
        else $error("values owed while idle");

    a_run_owes_some: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_remaining != '0))
        else $error("running with nothing owed");

    // The flagged last value ends the run.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_remaining == CNT_W'(1))) |=> (r_state == ST_IDLE) && r_out.last)
        else $error("run did not end on its last value");

endmodule

`default_nettype wire

### dv/tb_wichmann_hill_ii_uniform_generator_top.sv
`default_nettype none

module tb_wichmann_hill_ii_uniform_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import whu_pkg::*;

    localparam logic [MOD_W-1:0] SEED_MAX    = 31'd2147483646;
    localparam logic [MOD_W-1:0] MOD_MAX     = 31'd2147483647;
    localparam int               SETTLE_WAIT = 200;
    localparam int               QUIET_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    whu_in_if  in_ch ();
    whu_out_if out_ch ();
    whu_cfg_if cfg_ch ();

    wichmann_hill_ii_uniform_generator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the generator: component seeds and register settings.
    logic [MOD_W-1:0]  comp_state [NUM_COMP];
    logic [MULT_W-1:0] mult_reg   [NUM_COMP];
    logic [MOD_W-1:0]  mod_reg    [NUM_COMP];
    logic [MOD_W-1:0]  cfg_plan   [8];

    t_in_item  pending_cmds [$];
    t_out_item expected_values [$];
    t_out_item want;

    bit calm;
    int errors;
    int values_checked;
    int loads_seen;
    int runs_seen;
    int settings_used;
    int in_gap;
    int out_gap;
    int quiet_cycles;

    // One congruential step, product reduced at full width.
    function automatic logic [MOD_W-1:0] next_component(logic [MOD_W-1:0] s,
                                                        logic [MULT_W-1:0] a,
                                                        logic [MOD_W-1:0] m);
        logic [63:0] prod;
        if (m < 2)
            return '0;
        prod = 64'(a) * 64'(s);
        return MOD_W'(prod % 64'(m));
    endfunction

    // floor(s * 2^32 / m), the contribution of one component to the value.
    function automatic logic [VAL_W-1:0] scaled_share(logic [MOD_W-1:0] s,
                                                      logic [MOD_W-1:0] m);
        if (m < 2)
            return '0;
        return VAL_W'({1'b0, s, 32'b0} / 64'(m));
    endfunction

    // Apply one accepted command to the shadow state, queueing any values it yields.
    function automatic void predict_values(t_in_item it);
        int        n;
        t_out_item r;
        if (it.cmd == CMD_LOAD) begin
            comp_state[0] = it.seed_w;
            comp_state[1] = it.seed_x;
            comp_state[2] = it.seed_y;
            comp_state[3] = it.seed_z;
            loads_seen++;
            return;
        end
        runs_seen++;
        n = (it.count > MAX_RUN) ? MAX_RUN : int'(it.count);
        for (int k = 0; k < n; k++) begin
            r.value = '0;
            for (int c = 0; c < NUM_COMP; c++) begin
                comp_state[c] = next_component(comp_state[c], mult_reg[c], mod_reg[c]);
                r.value += scaled_share(comp_state[c], mod_reg[c]);
            end
            r.last = (k == n - 1);
            expected_values.push_back(r);
        end
    endfunction

    // Seeds spread over the whole range, near zero and around the modulus.
    function automatic logic [MOD_W-1:0] random_seed(int c);
        longint s;
        case ($urandom_range(0, 4))
            0: s = longint'($urandom_range(0, 100));
            1: s = longint'(mod_reg[c]) + longint'($urandom_range(0, 4)) - 2;
            default: s = longint'($urandom_range(0, SEED_MAX));
        endcase
        if (s < 0)
            s = 0;
        if (s > longint'(SEED_MAX))
            s = longint'(SEED_MAX);
        return MOD_W'(s);
    endfunction

    function automatic t_in_item random_cmd();
        t_in_item it;
        int       pick;
        it.seed_w = random_seed(0);
        it.seed_x = random_seed(1);
        it.seed_y = random_seed(2);
        it.seed_z = random_seed(3);
        if ($urandom_range(0, 4) == 0) begin
            it.cmd   = CMD_LOAD;
            it.count = CNT_W'($urandom_range(0, 127));
        end else begin
            it.cmd = CMD_GENERATE;
            pick   = $urandom_range(0, 99);
            if (pick < 4)
                it.count = '0;
            else if (pick < 8)
                it.count = CNT_W'($urandom_range(65, 127));
            else if (pick < 11)
                it.count = CNT_W'(MAX_RUN);
            else if (pick < 28)
                it.count = CNT_W'($urandom_range(9, 40));
            else
                it.count = CNT_W'($urandom_range(1, 8));
        end
        return it;
    endfunction

    task automatic push_gen(input logic [CNT_W-1:0] count);
        t_in_item it;
        it.cmd    = CMD_GENERATE;
        it.count  = count;
        it.seed_w = MOD_W'($urandom());
        it.seed_x = MOD_W'($urandom());
        it.seed_y = MOD_W'($urandom());
        it.seed_z = MOD_W'($urandom());
        pending_cmds.push_back(it);
    endtask

    task automatic push_load(input logic [MOD_W-1:0] w, input logic [MOD_W-1:0] x,
                             input logic [MOD_W-1:0] y, input logic [MOD_W-1:0] z,
                             input logic [CNT_W-1:0] count);
        t_in_item it;
        it.cmd    = CMD_LOAD;
        it.count  = count;
        it.seed_w = w;
        it.seed_x = x;
        it.seed_y = y;
        it.seed_z = z;
        pending_cmds.push_back(it);
    endtask

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++)
            pending_cmds.push_back(random_cmd());
    endtask

    // Called just after a rising edge; returns at the edge of the transfer.
    // The low two index bits select the component within each register group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MOD_W-1:0] data);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.item.index <= idx;
        cfg_ch.item.data  <= data;
        do
            @(posedge i_clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        if (idx < REG_MOD_W)
            mult_reg[idx[1:0]] = data[MULT_W-1:0];
        else
            mod_reg[idx[1:0]] = data;
    endtask

    task automatic apply_plan();
        for (int r = REG_MULT_W; r <= REG_MOD_Z; r++)
            write_reg(CFG_IDX_W'(r), cfg_plan[r]);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic random_plan();
        for (int c = 0; c < NUM_COMP; c++) begin
            cfg_plan[REG_MULT_W + c] = {15'($urandom()), 16'($urandom_range(1, 65535))};
            if ($urandom_range(0, 3) == 0)
                cfg_plan[REG_MOD_W + c] = MOD_W'($urandom_range(2, 5000));
            else
                cfg_plan[REG_MOD_W + c] = MOD_W'($urandom_range(2, MOD_MAX));
        end
    endtask

    // Wait for every command to be taken and every value to come back, then let
    // the block finish any work that yields nothing.
    task automatic settle();
        do
            @(posedge i_clk);
        while (pending_cmds.size() != 0 || in_ch.valid || expected_values.size() != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Command driver: holds each command until it is taken, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_values(in_ch.item);
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.item  <= pending_cmds.pop_front();
                    if (!calm && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 15);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Value monitor: checks each transfer against the oldest prediction and
    // stalls the output in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_values.size() == 0) begin
                    errors++;
                    $display("%0t: value %h last %b arrived with none expected",
                             $time, out_ch.item.value, out_ch.item.last);
                end else begin
                    want = expected_values.pop_front();
                    values_checked++;
                    if (out_ch.item.value !== want.value) begin
                        errors++;
                        $display("%0t: value expected %h actual %h",
                                 $time, want.value, out_ch.item.value);
                    end
                    if (out_ch.item.last !== want.last) begin
                        errors++;
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, out_ch.item.last);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    out_gap = $urandom_range(1, 15);
            end
        end
    end

    // Watchdog: a long stretch without any transfer means the block has hung.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d values outstanding",
                     $time, quiet_cycles, expected_values.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.item      = '0;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.item     = '0;
        calm            = 1'b0;
        errors          = 0;
        values_checked  = 0;
        loads_seen      = 0;
        runs_seen       = 0;
        settings_used   = 1;
        quiet_cycles    = 0;
        for (int c = 0; c < NUM_COMP; c++) begin
            comp_state[c] = COMP_RESET[c];
            mult_reg[c]   = MULT_RESET[c];
            mod_reg[c]    = MOD_RESET[c];
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: run lengths at and beyond the limit, an empty run,
        // seeds at or above the moduli, zero seeds and load with a stray count.
        push_gen(7'd1);
        push_gen(7'd0);
        push_gen(7'd64);
        push_gen(7'd65);
        push_gen(7'd127);
        push_load(SEED_MAX, SEED_MAX, SEED_MAX, SEED_MAX, 7'd0);
        push_gen(7'd2);
        push_load(MOD_RESET[0], MOD_RESET[1], MOD_RESET[2], MOD_RESET[3], 7'd127);
        push_gen(7'd3);
        push_load('0, '0, '0, '0, 7'd5);
        push_gen(7'd1);
        push_load(31'h2AAAAAAA, 31'h55555555, 31'd1, 31'h40000000, 7'd0);
        push_gen(7'd4);
        push_random(40);
        settle();

        // Largest multipliers and moduli.
        for (int c = 0; c < NUM_COMP; c++) begin
            cfg_plan[REG_MULT_W + c] = 31'd65535;
            cfg_plan[REG_MOD_W + c]  = MOD_MAX;
        end
        apply_plan();
        push_load(SEED_MAX, SEED_MAX, SEED_MAX, SEED_MAX, 7'd0);
        push_gen(7'd3);
        push_random(45);
        settle();

        // Smallest legal multipliers and moduli.
        for (int c = 0; c < NUM_COMP; c++) begin
            cfg_plan[REG_MULT_W + c] = 31'd1;
            cfg_plan[REG_MOD_W + c]  = 31'd2;
        end
        apply_plan();
        push_random(40);
        settle();

        // Degenerate components: a zero multiplier and moduli below two.
        cfg_plan[REG_MULT_W] = 31'd0;
        cfg_plan[REG_MULT_X] = 31'd65535;
        cfg_plan[REG_MULT_Y] = 31'd12345;
        cfg_plan[REG_MULT_Z] = 31'd1;
        cfg_plan[REG_MOD_W]  = MOD_MAX;
        cfg_plan[REG_MOD_X]  = 31'd1;
        cfg_plan[REG_MOD_Y]  = 31'd0;
        cfg_plan[REG_MOD_Z]  = 31'd3;
        apply_plan();
        push_load(31'd5, 31'd6, 31'd7, 31'd8, 7'd0);
        push_gen(7'd4);
        push_random(40);
        settle();

        // Random settings.
        random_plan();
        apply_plan();
        push_random(40);
        settle();

        // Random settings again; the tail runs with no idling on either side.
        random_plan();
        apply_plan();
        push_random(60);
        while (pending_cmds.size() > 25)
            @(posedge i_clk);
        calm = 1'b1;
        settle();

        $display("Ran %0d commands (%0d seed loads, %0d generate runs)",
                 loads_seen + runs_seen, loads_seen, runs_seen);
        $display("over %0d register settings; compared %0d uniform values, %0d mismatches.",
                 settings_used, values_checked, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
